@@ hdl/brm_pkg.sv @@
// Shared types, opcodes and helper functions for the bound-IP register machine.
`timescale 1ns / 1ps
`default_nettype none

package brm_pkg;

  localparam int NUM_REGS_DEF = 6;
  localparam int FUNC_W       = 4;
  localparam int DEST_W       = 3;
  localparam int OPND_W       = 32;
  localparam int DATA_W       = 64;
  localparam int BIND_W       = 3;
  localparam int PLEN_W       = 16;
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADDR = 4'd0,
    FN_ADDI = 4'd1,
    FN_MULR = 4'd2,
    FN_MULI = 4'd3,
    FN_BANR = 4'd4,
    FN_BANI = 4'd5,
    FN_BORR = 4'd6,
    FN_BORI = 4'd7,
    FN_SETR = 4'd8,
    FN_SETI = 4'd9,
    FN_GTIR = 4'd10,
    FN_GTRI = 4'd11,
    FN_GTRR = 4'd12,
    FN_EQIR = 4'd13,
    FN_EQRI = 4'd14,
    FN_EQRR = 4'd15
  } func_e;

  typedef struct packed {
    logic [BIND_W-1:0] ip_binding;
    logic [PLEN_W-1:0] prog_length;
  } cfg_t;

  typedef struct packed {
    logic wr;       // any register write this cycle
    logic bind_wr;  // ip_binding is being rewritten this cycle
  } cfg_evt_t;

  function automatic logic op_a_is_reg(input func_e f);
    logic r;
    case (f)
      FN_SETI, FN_GTIR, FN_EQIR: r = 1'b0;
      default:                   r = 1'b1;
    endcase
    return r;
  endfunction

  function automatic logic op_b_is_reg(input func_e f);
    logic r;
    case (f)
      FN_ADDR, FN_MULR, FN_BANR, FN_BORR,
      FN_GTIR, FN_GTRR, FN_EQIR, FN_EQRR: r = 1'b1;
      default:                            r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic func_is_mul(input func_e f);
    logic r;
    case (f)
      FN_MULR, FN_MULI: r = 1'b1;
      default:          r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/brm_ram.sv @@
// Generic register-file RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module brm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 6,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_a_i,
  input  wire logic [AW-1:0]    raddr_b_i,
  output logic      [WIDTH-1:0] rdata_a_o,
  output logic      [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

@@ hdl/brm_cfg.sv @@
// APB configuration registers: ip_binding and program_length.
`timescale 1ns / 1ps
`default_nettype none

module brm_cfg
  import brm_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output cfg_t                    cfg_o,
  output cfg_evt_t                evt_o
);

  typedef enum logic {
    REG_IP_BINDING = 1'b0,
    REG_PROG_LEN   = 1'b1
  } reg_idx_e;

  cfg_t     cfg_q;
  logic     wr;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr) begin
      case (idx)
        REG_IP_BINDING: cfg_q.ip_binding  <= pwdata[BIND_W-1:0];
        REG_PROG_LEN:   cfg_q.prog_length <= pwdata[PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_IP_BINDING: prdata = PDATA_W'(cfg_q.ip_binding);
      REG_PROG_LEN:   prdata = PDATA_W'(cfg_q.prog_length);
      default:        prdata = '0;
    endcase
  end

  assign cfg_o         = cfg_q;
  assign evt_o.wr      = wr;
  assign evt_o.bind_wr = wr && (idx == REG_IP_BINDING);

endmodule

`default_nettype wire

@@ hdl/brm_alu.sv @@
// ALU with a three-step 32x32 multiply sequencer for 64-bit wrapping products.
`timescale 1ns / 1ps
`default_nettype none

module brm_alu
  import brm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire func_e             func_i,
  input  wire logic [DATA_W-1:0] va_i,
  input  wire logic [DATA_W-1:0] vb_i,
  input  wire logic              run_i,   // multiply in EX, not faulting
  input  wire logic              take_i,  // EX completes this cycle
  output logic      [DATA_W-1:0] res_o,
  output logic                   ready_o
);

  localparam int HW = DATA_W / 2;

  typedef enum logic [1:0] {
    STEP_LL   = 2'd0,
    STEP_LH   = 2'd1,
    STEP_HL   = 2'd2,
    STEP_DONE = 2'd3
  } step_e;

  step_e             step_q;
  step_e             step_d;
  logic [DATA_W-1:0] acc_q;
  logic [DATA_W-1:0] acc_d;
  logic [HW-1:0]     mx;
  logic [HW-1:0]     my;
  logic [DATA_W-1:0] prod;

  always_comb begin
    case (step_q)
      STEP_LL: begin mx = va_i[HW-1:0];      my = vb_i[HW-1:0];      end
      STEP_LH: begin mx = va_i[HW-1:0];      my = vb_i[DATA_W-1:HW]; end
      default: begin mx = va_i[DATA_W-1:HW]; my = vb_i[HW-1:0];      end
    endcase
  end

  always_comb begin
    case (step_q)
      STEP_LL: step_d = STEP_LH;
      STEP_LH: step_d = STEP_HL;
      default: step_d = STEP_DONE;
    endcase
  end

  assign prod = DATA_W'(mx) * DATA_W'(my);

  always_comb begin
    if (step_q == STEP_LL) begin
      acc_d = prod;
    end else begin
      acc_d = acc_q + {prod[HW-1:0], {HW{1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_LL;
      acc_q  <= '0;
    end else if (take_i) begin
      step_q <= STEP_LL;
    end else if (run_i && step_q != STEP_DONE) begin
      step_q <= step_d;
      acc_q  <= acc_d;
    end
  end

  always_comb begin
    case (func_i)
      FN_ADDR, FN_ADDI:          res_o = va_i + vb_i;
      FN_MULR, FN_MULI:          res_o = acc_q;
      FN_BANR, FN_BANI:          res_o = va_i & vb_i;
      FN_BORR, FN_BORI:          res_o = va_i | vb_i;
      FN_SETR, FN_SETI:          res_o = va_i;
      FN_GTIR, FN_GTRI, FN_GTRR: res_o = DATA_W'($signed(va_i) > $signed(vb_i));
      FN_EQIR, FN_EQRI, FN_EQRR: res_o = DATA_W'(va_i == vb_i);
      default:                   res_o = '0;
    endcase
  end

  assign ready_o = !func_is_mul(func_i) || (step_q == STEP_DONE);

endmodule

`default_nettype wire

@@ hdl/bound_ip_register_machine_unit.sv @@
// Top level of the register machine with a bound instruction pointer.
`timescale 1ns / 1ps
`default_nettype none

// Runs one instruction per input word on NUM_REGS signed 64-bit registers, one
// of which (ip_binding) mirrors the instruction pointer. A word is taken into
// an execute register while the register file RAM is read, and its result word
// lands in the output register when the execute stage completes. Add, logic,
// set and compare instructions sustain one word per cycle while the output is
// not stalled; back-to-back dependencies are forwarded. mulr and muli hold the
// execute stage until the sequencer is done: the 64-bit wrapping product is
// built from three partial products through a single 32x32 multiplier.
// Configuration writes stall input for their cycle; writing ip_binding also
// flushes the old bound register's value into the register file.
module bound_ip_register_machine_unit
  import brm_pkg::*;
#(
  parameter int NUM_REGS = NUM_REGS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic        [FUNC_W-1:0] func_i,
  input  wire logic signed [OPND_W-1:0] operand_a_i,
  input  wire logic signed [OPND_W-1:0] operand_b_i,
  input  wire logic        [DEST_W-1:0] dest_reg_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic signed      [DATA_W-1:0] next_ip_o,
  output logic signed      [DATA_W-1:0] written_value_o,
  output logic                          halted_o,
  output logic                          fault_o,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic       [PADDR_W-1:0] paddr,
  input  wire logic       [PDATA_W-1:0] pwdata,
  output logic            [PDATA_W-1:0] prdata,
  output logic                          pready
);

  localparam int AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  cfg_t     cfg;
  cfg_evt_t cfg_evt;

  // execute stage
  logic              ex_valid_q;
  func_e             ex_func_q;
  logic [OPND_W-1:0] ex_op_a_q;
  logic [OPND_W-1:0] ex_op_b_q;
  logic [DEST_W-1:0] ex_dst_q;
  logic              a_vld_q, b_vld_q;
  logic              byp_a_hit_q, byp_b_hit_q;
  logic [DATA_W-1:0] byp_a_q, byp_b_q;
  logic [DATA_W-1:0] ram_a, ram_b;

  logic [DATA_W-1:0]   ip_q;
  logic                dirty_q;
  logic [NUM_REGS-1:0] reg_vld_q;

  logic              out_valid_q;
  logic [DATA_W-1:0] out_ip_q;
  logic [DATA_W-1:0] out_wv_q;
  logic              out_fault_q;

  logic              in_acc;
  logic [AW-1:0]     in_addr_a, in_addr_b;
  logic              vld_a_hit, vld_b_hit;
  logic              ex_fault, ex_done, ex_go, ex_wr;
  logic              alu_ready;
  logic [DATA_W-1:0] ra_val, rb_val, va, vb, res;
  logic [DATA_W-1:0] ip_next;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              a_bad, b_bad, dst_bad, ipb_bad;

  brm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg),
    .evt_o   (cfg_evt)
  );

  // ---- input side ----
  assign in_stall_o = (ex_valid_q && !ex_go) || cfg_evt.wr;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_addr_a  = AW'(operand_a_i);
  assign in_addr_b  = AW'(operand_b_i);

  always_comb begin
    vld_a_hit = 1'b0;
    vld_b_hit = 1'b0;
    for (int i = 0; i < NUM_REGS; i++) begin
      if (in_addr_a == AW'(i)) vld_a_hit = reg_vld_q[i];
      if (in_addr_b == AW'(i)) vld_b_hit = reg_vld_q[i];
    end
  end

  // ---- execute ----
  assign ipb_bad = 32'(cfg.ip_binding) >= 32'(NUM_REGS);
  assign dst_bad = 32'(ex_dst_q) >= 32'(NUM_REGS);
  assign a_bad   = op_a_is_reg(ex_func_q) &&
                   (ex_op_a_q[OPND_W-1] || (ex_op_a_q >= 32'(NUM_REGS)));
  assign b_bad   = op_b_is_reg(ex_func_q) &&
                   (ex_op_b_q[OPND_W-1] || (ex_op_b_q >= 32'(NUM_REGS)));
  assign ex_fault = ipb_bad || dst_bad || a_bad || b_bad;

  // the bound register always reads as the current pointer
  always_comb begin
    if (ex_op_a_q == 32'(cfg.ip_binding))   ra_val = ip_q;
    else if (byp_a_hit_q)                   ra_val = byp_a_q;
    else if (a_vld_q)                       ra_val = ram_a;
    else                                    ra_val = '0;
    if (ex_op_b_q == 32'(cfg.ip_binding))   rb_val = ip_q;
    else if (byp_b_hit_q)                   rb_val = byp_b_q;
    else if (b_vld_q)                       rb_val = ram_b;
    else                                    rb_val = '0;
  end

  assign va = op_a_is_reg(ex_func_q) ? ra_val : {{(DATA_W-OPND_W){ex_op_a_q[OPND_W-1]}}, ex_op_a_q};
  assign vb = op_b_is_reg(ex_func_q) ? rb_val : {{(DATA_W-OPND_W){ex_op_b_q[OPND_W-1]}}, ex_op_b_q};

  brm_alu u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .func_i  (ex_func_q),
    .va_i    (va),
    .vb_i    (vb),
    .run_i   (ex_valid_q && !ex_fault && func_is_mul(ex_func_q)),
    .take_i  (ex_go),
    .res_o   (res),
    .ready_o (alu_ready)
  );

  assign ex_done = ex_fault || alu_ready;
  assign ex_go   = ex_valid_q && ex_done && (!out_valid_q || !out_stall_i);
  assign ex_wr   = ex_go && !ex_fault;
  assign ip_next = ((ex_dst_q == cfg.ip_binding) ? res : ip_q) + DATA_W'(1);

  // ---- register file ----
  assign ram_we    = ex_wr || (cfg_evt.bind_wr && dirty_q);
  assign ram_waddr = ex_wr ? AW'(ex_dst_q) : AW'(cfg.ip_binding);
  assign ram_wdata = ex_wr ? res : (ip_q - DATA_W'(1));

  brm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (NUM_REGS)
  ) u_regs (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .re_i      (in_acc),
    .raddr_a_i (in_addr_a),
    .raddr_b_i (in_addr_b),
    .rdata_a_o (ram_a),
    .rdata_b_o (ram_b)
  );

  // ---- control state ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q  <= 1'b0;
      ip_q        <= '0;
      dirty_q     <= 1'b0;
      reg_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        ex_valid_q <= 1'b1;
      end else if (ex_go) begin
        ex_valid_q <= 1'b0;
      end
      if (ex_wr) begin
        ip_q    <= ip_next;
        dirty_q <= 1'b1;
      end else if (cfg_evt.bind_wr) begin
        dirty_q <= 1'b0;
      end
      for (int i = 0; i < NUM_REGS; i++) begin
        if (ram_we && ram_waddr == AW'(i)) reg_vld_q[i] <= 1'b1;
      end
      if (ex_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---- payload ----
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ex_func_q   <= func_e'(func_i);
      ex_op_a_q   <= operand_a_i;
      ex_op_b_q   <= operand_b_i;
      ex_dst_q    <= dest_reg_i;
      a_vld_q     <= vld_a_hit;
      b_vld_q     <= vld_b_hit;
      byp_a_hit_q <= ex_wr && (AW'(ex_dst_q) == in_addr_a);
      byp_b_hit_q <= ex_wr && (AW'(ex_dst_q) == in_addr_b);
      byp_a_q     <= res;
      byp_b_q     <= res;
    end
    if (ex_go) begin
      out_ip_q    <= ex_fault ? ip_q : ip_next;
      out_wv_q    <= ex_fault ? '0 : res;
      out_fault_q <= ex_fault;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign next_ip_o       = out_ip_q;
  assign written_value_o = out_wv_q;
  assign fault_o         = out_fault_q;
  assign halted_o        = out_ip_q[DATA_W-1] || (out_ip_q[DATA_W-2:PLEN_W] != '0) ||
                           (out_ip_q[PLEN_W-1:0] >= cfg.prog_length);

endmodule

`default_nettype wire

@@ tb/brm_step_checker.sv @@
// Predicts and checks every result word of the bound-IP register machine.
`timescale 1ns / 1ps
`default_nettype none

module brm_step_checker
  import brm_pkg::*;
#(
  parameter logic [PADDR_W-1:0] BIND_ADDR = '0,
  parameter logic [PADDR_W-1:0] PLEN_ADDR = '0
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  input  wire logic                     in_stall_i,
  input  wire logic        [FUNC_W-1:0] func_i,
  input  wire logic        [OPND_W-1:0] operand_a_i,
  input  wire logic        [OPND_W-1:0] operand_b_i,
  input  wire logic        [DEST_W-1:0] dest_reg_i,
  input  wire logic                     out_valid_i,
  input  wire logic                     out_stall_i,
  input  wire logic        [DATA_W-1:0] next_ip_i,
  input  wire logic        [DATA_W-1:0] written_value_i,
  input  wire logic                     halted_i,
  input  wire logic                     fault_i,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic       [PADDR_W-1:0] paddr,
  input  wire logic       [PDATA_W-1:0] pwdata,
  input  wire logic                     pready,
  output int                            errors_o,
  output int                            pending_o
);

  localparam int NREGS = NUM_REGS_DEF;

  typedef struct packed {
    logic [DATA_W-1:0] next_ip;
    logic [DATA_W-1:0] wval;
    logic              halted;
    logic              fault;
  } step_t;

  logic [DATA_W-1:0] regs [NREGS];
  logic [DATA_W-1:0] ip;
  logic [BIND_W-1:0] bound_idx;
  logic [PLEN_W-1:0] plen;
  step_t             expected_steps[$];
  step_t             want;
  int                err_cnt;

  assign errors_o = err_cnt;

  function automatic logic idx_ok(input logic [OPND_W-1:0] v);
    return !v[OPND_W-1] && (v < NREGS);
  endfunction

  function automatic logic ip_halts(input logic [DATA_W-1:0] p);
    return p[DATA_W-1] || (p >= {{(DATA_W-PLEN_W){1'b0}}, plen});
  endfunction

  function automatic step_t execute_step(input func_e f, input logic [OPND_W-1:0] a,
                                         input logic [OPND_W-1:0] b,
                                         input logic [DEST_W-1:0] d);
    step_t             r;
    logic              a_reg, b_reg;
    logic [DATA_W-1:0] va, vb, res;
    case (f)
      FN_SETI, FN_GTIR, FN_EQIR: a_reg = 1'b0;
      default:                   a_reg = 1'b1;
    endcase
    case (f)
      FN_ADDR, FN_MULR, FN_BANR, FN_BORR, FN_GTIR, FN_GTRR, FN_EQIR, FN_EQRR: b_reg = 1'b1;
      default: b_reg = 1'b0;
    endcase
    if (bound_idx >= NREGS || d >= NREGS || (a_reg && !idx_ok(a)) || (b_reg && !idx_ok(b))) begin
      r.next_ip = ip;
      r.wval    = '0;
      r.halted  = ip_halts(ip);
      r.fault   = 1'b1;
      return r;
    end
    regs[bound_idx] = ip;
    va = a_reg ? regs[a[2:0]] : {{(DATA_W-OPND_W){a[OPND_W-1]}}, a};
    vb = b_reg ? regs[b[2:0]] : {{(DATA_W-OPND_W){b[OPND_W-1]}}, b};
    case (f)
      FN_ADDR, FN_ADDI:          res = va + vb;
      FN_MULR, FN_MULI:          res = va * vb;
      FN_BANR, FN_BANI:          res = va & vb;
      FN_BORR, FN_BORI:          res = va | vb;
      FN_SETR, FN_SETI:          res = va;
      FN_GTIR, FN_GTRI, FN_GTRR: res = ($signed(va) > $signed(vb)) ? 64'd1 : 64'd0;
      default:                   res = (va == vb) ? 64'd1 : 64'd0;
    endcase
    regs[d] = res;
    ip = regs[bound_idx] + 64'd1;
    r.next_ip = ip;
    r.wval    = res;
    r.halted  = ip_halts(ip);
    r.fault   = 1'b0;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NREGS; i++) regs[i] = '0;
      ip        = '0;
      bound_idx = '0;
      plen      = '0;
      expected_steps.delete();
      err_cnt   = 0;
      pending_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          BIND_ADDR: bound_idx = pwdata[BIND_W-1:0];
          PLEN_ADDR: plen = pwdata[PLEN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        want = execute_step(func_e'(func_i), operand_a_i, operand_b_i, dest_reg_i);
        expected_steps = {expected_steps, want};
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_steps.size() == 0) begin
          $display("%0t: unexpected result word next_ip=%h", $time, next_ip_i);
          err_cnt++;
        end else begin
          want = expected_steps.pop_front();
          if (next_ip_i !== want.next_ip) begin
            $display("%0t: next_ip exp %h got %h", $time, want.next_ip, next_ip_i);
            err_cnt++;
          end
          if (written_value_i !== want.wval) begin
            $display("%0t: written_value exp %h got %h", $time, want.wval, written_value_i);
            err_cnt++;
          end
          if (halted_i !== want.halted) begin
            $display("%0t: halted exp %b got %b", $time, want.halted, halted_i);
            err_cnt++;
          end
          if (fault_i !== want.fault) begin
            $display("%0t: fault exp %b got %b", $time, want.fault, fault_i);
            err_cnt++;
          end
        end
      end
      pending_o <= expected_steps.size();
    end
  end

endmodule

`default_nettype wire

@@ tb/bound_ip_register_machine_unit_tb.sv @@
// Stimulus, configuration and verdict for the bound-IP register machine.
`timescale 1ns / 1ps
`default_nettype none

module bound_ip_register_machine_unit_tb
  import brm_pkg::*;
();

  localparam logic [PADDR_W-1:0] BIND_ADDR = 3'd0;
  localparam logic [PADDR_W-1:0] PLEN_ADDR = 3'd4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES = 6;
  localparam int WORDS_PER_PHASE = 110;

  typedef struct packed {
    func_e             func;
    logic [OPND_W-1:0] a;
    logic [OPND_W-1:0] b;
    logic [DEST_W-1:0] d;
  } word_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i, in_stall_o;
  logic [FUNC_W-1:0] func_i;
  logic signed [OPND_W-1:0] operand_a_i, operand_b_i;
  logic [DEST_W-1:0] dest_reg_i;
  logic out_valid_o, out_stall_i;
  logic signed [DATA_W-1:0] next_ip_o, written_value_o;
  logic halted_o, fault_o;
  logic psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;
  logic noise_on;
  int errors, pending, cycle_cnt;

  bound_ip_register_machine_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .func_i, .operand_a_i, .operand_b_i,
    .dest_reg_i, .out_valid_o, .out_stall_i, .next_ip_o, .written_value_o, .halted_o,
    .fault_o, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  brm_step_checker #(.BIND_ADDR(BIND_ADDR), .PLEN_ADDR(PLEN_ADDR)) u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .func_i, .operand_a_i,
    .operand_b_i, .dest_reg_i, .out_valid_i(out_valid_o), .out_stall_i,
    .next_ip_i(next_ip_o), .written_value_i(written_value_o), .halted_i(halted_o),
    .fault_i(fault_o), .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .errors_o(errors), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial out_stall_i <= 1'b0;
  always @(posedge clk_i) out_stall_i <= noise_on && ($urandom_range(0, 99) < 31);

  initial cycle_cnt = 0;
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_word(input word_t w);
    while (noise_on && $urandom_range(0, 99) < 31) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    func_i      <= w.func;
    operand_a_i <= w.a;
    operand_b_i <= w.b;
    dest_reg_i  <= w.d;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [OPND_W-1:0] rand_operand();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 80) return $urandom_range(0, 5);
    if (sel < 87) return $urandom_range(0, 40);
    if (sel < 90) return -$urandom_range(1, 40);
    if (sel < 97) return $urandom();
    case ($urandom_range(0, 3))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      default: return 32'd6;
    endcase
  endfunction

  function automatic word_t rand_word();
    word_t w;
    w.func = func_e'(FUNC_W'($urandom_range(0, 15)));
    w.a    = rand_operand();
    w.b    = rand_operand();
    w.d    = ($urandom_range(0, 99) < 93) ? DEST_W'($urandom_range(0, 5)) :
                                            DEST_W'($urandom_range(6, 7));
    return w;
  endfunction

  initial begin
    word_t directed[$];
    int bind_sel[PHASES];
    int plen_sel[PHASES];
    bind_sel = '{0, 5, 3, 1, 4, 2};
    plen_sel = '{0, 65535, 16, 40, 1, 300};
    rst_ni      <= 1'b0;
    noise_on    <= 1'b1;
    in_valid_i  <= 1'b0;
    func_i      <= '0;
    operand_a_i <= '0;
    operand_b_i <= '0;
    dest_reg_i  <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    reg_write(BIND_ADDR, 32'd2);
    reg_write(PLEN_ADDR, 32'd20);
    directed = '{
      '{FN_SETI, 32'h7FFF_FFFF, 32'h0,         3'd1},
      '{FN_SETI, 32'h8000_0000, 32'h0,         3'd3},
      '{FN_ADDR, 32'd1,         32'd1,         3'd4},
      '{FN_MULR, 32'd4,         32'd4,         3'd5},
      '{FN_MULI, 32'd3,         32'h7FFF_FFFF, 3'd0},
      '{FN_ADDI, 32'd5,         32'hFFFF_FFFF, 3'd4},
      '{FN_BANR, 32'd4,         32'd5,         3'd0},
      '{FN_BANI, 32'd3,         32'hFFFF_FFFF, 3'd1},
      '{FN_BORR, 32'd0,         32'd1,         3'd4},
      '{FN_BORI, 32'd4,         32'h8000_0000, 3'd5},
      // setr ignores operand b, so a bad index there is harmless
      '{FN_SETR, 32'd5,         32'hFFFF_FFFF, 3'd0},
      '{FN_GTIR, 32'h7FFF_FFFF, 32'd5,         3'd1},
      '{FN_GTRI, 32'd3,         32'h8000_0000, 3'd4},
      '{FN_GTRR, 32'd0,         32'd1,         3'd5},
      '{FN_EQIR, 32'hFFFF_FFFF, 32'd1,         3'd0},
      '{FN_EQRI, 32'd1,         32'd1,         3'd0},
      '{FN_EQRR, 32'd2,         32'd2,         3'd3},
      // write to the bound register: jump
      '{FN_SETI, 32'd5,         32'h8000_0000, 3'd2},
      '{FN_ADDI, 32'd2,         32'hFFFF_FF9C, 3'd2},
      '{FN_ADDR, 32'd6,         32'd0,         3'd1},
      '{FN_MULR, 32'd0,         32'h8000_0000, 3'd1},
      '{FN_BANR, 32'hFFFF_FFFF, 32'd0,         3'd1},
      '{FN_ADDI, 32'd0,         32'd1,         3'd6},
      '{FN_SETI, 32'd0,         32'd0,         3'd7},
      '{FN_SETI, 32'd3,         32'd0,         3'd2}
    };
    foreach (directed[i]) send_word(directed[i]);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      reg_write(BIND_ADDR, bind_sel[p]);
      reg_write(PLEN_ADDR, plen_sel[p]);
      noise_on <= (p != 2);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        send_word(rand_word());
        if (p == 3 && n == WORDS_PER_PHASE / 2) drain();
      end
      drain();
    end

    noise_on <= 1'b0;
    repeat (8) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
